### hdl/ipv4spc_pkg.sv
// ----------------------------------------------------------------------------
// ipv4spc_pkg
// Shared types and constants of the IPv4 source packet counter.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4spc_pkg;

    localparam int ENTRIES = 4096;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int USED_W  = IDX_W + 1;

    localparam logic [15:0] ETH_HEADER_BYTES = 16'd14;
    localparam logic [15:0] IPV4_MIN_BYTES   = 16'd34;
    localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;

    typedef enum logic [1:0] {
        OUTCOME_COUNTED   = 2'd0,
        OUTCOME_SHORT_ETH = 2'd1,
        OUTCOME_NOT_IPV4  = 2'd2,
        OUTCOME_SHORT_IP  = 2'd3
    } outcome_t;

    typedef struct packed {
        logic [15:0] frame_length;
        logic [15:0] ether_type;
        logic [31:0] source_address;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [31:0] flow_address;
        logic [63:0] packet_total;
        logic        evicted;
        logic [31:0] evicted_address;
    } out_item_t;

endpackage

`default_nettype wire

### hdl/ipv4spc_if.sv
// ----------------------------------------------------------------------------
// ipv4spc_in_if / ipv4spc_out_if
// Valid/ready channels for frame headers and counter results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipv4spc_in_if
    import ipv4spc_pkg::*;
;
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ipv4spc_out_if
    import ipv4spc_pkg::*;
;
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/ipv4_source_packet_counter_lru.sv
// ----------------------------------------------------------------------------
// ipv4_source_packet_counter_lru
// Per-source IPv4 frame counter with an exact LRU table in block RAM.
// ----------------------------------------------------------------------------
// One frame header is handled at a time. A frame that fails the length or
// EtherType checks goes straight to the done state, whence its result enters
// the output register once that is free. A counted frame scans the key RAM
// one entry per cycle over the entries in use; a hit, or a miss that evicts
// the tail, then passes the read, unlink and relink states, and a miss that
// takes a free slot goes to the insert state. Recency is kept as a doubly
// linked list in RAM, so the victim (the list tail) costs nothing to find.
// Slots fill from 0 upward; the fill count marks which slots are valid, so
// no clearing pass follows reset. A finished result waits in an output
// register while the next frame is taken.
`default_nettype none

module ipv4_source_packet_counter_lru
    import ipv4spc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    ipv4spc_in_if.sink   in_ch,
    ipv4spc_out_if.source out_ch
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SCAN = 7'b0000010,
        ST_RD   = 7'b0000100,
        ST_MOV1 = 7'b0001000,
        ST_MOV2 = 7'b0010000,
        ST_INS  = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0]      key_mem  [ENTRIES];
    logic [63:0]      cnt_mem  [ENTRIES];
    logic [IDX_W-1:0] prev_mem [ENTRIES];
    logic [IDX_W-1:0] next_mem [ENTRIES];

    logic [31:0]      key_q;
    logic [63:0]      cnt_q;
    logic [IDX_W-1:0] prev_q, next_q;

    logic [IDX_W-1:0] raddr;
    logic             key_we, cnt_we, prev_we, next_we;
    logic [IDX_W-1:0] key_wa, cnt_wa, prev_wa, next_wa;
    logic [31:0]      key_wd;
    logic [63:0]      cnt_wd;
    logic [IDX_W-1:0] prev_wd, next_wd;

    logic [USED_W-1:0] used_reg, used_next;
    logic [IDX_W-1:0]  head_reg, head_next, tail_reg, tail_next;
    logic [USED_W-1:0] scan_reg, scan_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  ridx_reg, ridx_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic              hit_reg, hit_next;
    logic [31:0]       addr_reg, addr_next;
    out_item_t         res_reg, res_next;
    out_item_t         out_reg, out_next;
    logic              ovalid_reg, ovalid_next;

    // RAMs: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_wa] <= key_wd;
        end
        key_q <= key_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        cnt_q <= cnt_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        prev_q <= prev_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        next_q <= next_mem[raddr];
    end

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = out_reg;

    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        scan_next   = scan_reg;
        pend_next   = pend_reg;
        ridx_next   = ridx_reg;
        slot_next   = slot_reg;
        hit_next    = hit_reg;
        addr_next   = addr_reg;
        res_next    = res_reg;
        out_next    = out_reg;
        ovalid_next = ovalid_reg;
        raddr       = slot_reg;
        key_we  = 1'b0; key_wa  = slot_reg; key_wd  = addr_reg;
        cnt_we  = 1'b0; cnt_wa  = slot_reg; cnt_wd  = 64'd1;
        prev_we = 1'b0; prev_wa = head_reg; prev_wd = slot_reg;
        next_we = 1'b0; next_wa = slot_reg; next_wd = head_reg;

        if (ovalid_reg && out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    addr_next = in_ch.data.source_address;
                    res_next  = '0;
                    scan_next = '0;
                    pend_next = 1'b0;
                    if (in_ch.data.frame_length < ETH_HEADER_BYTES)
                    begin
                        res_next.outcome = OUTCOME_SHORT_ETH;
                        state_next = ST_DONE;
                    end
                    else if (in_ch.data.ether_type != ETHERTYPE_IPV4)
                    begin
                        res_next.outcome = OUTCOME_NOT_IPV4;
                        state_next = ST_DONE;
                    end
                    else if (in_ch.data.frame_length < IPV4_MIN_BYTES)
                    begin
                        res_next.outcome = OUTCOME_SHORT_IP;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                raddr = scan_reg[IDX_W-1:0];
                if (pend_reg && key_q == addr_reg)
                begin
                    slot_next  = ridx_reg;
                    hit_next   = 1'b1;
                    state_next = ST_RD;
                end
                else if (scan_reg < used_reg)
                begin
                    pend_next = 1'b1;
                    ridx_next = scan_reg[IDX_W-1:0];
                    scan_next = scan_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        hit_next = 1'b0;
                        if (used_reg == USED_W'(ENTRIES))
                        begin
                            slot_next  = tail_reg;
                            state_next = ST_RD;
                        end
                        else
                        begin
                            slot_next  = used_reg[IDX_W-1:0];
                            state_next = ST_INS;
                        end
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_MOV1;
            end
            ST_MOV1:
            begin
                // unlink the slot from its place in the recency list and build the result
                res_next.flow_address = addr_reg;
                res_next.outcome      = OUTCOME_COUNTED;
                res_next.packet_total = hit_reg ? cnt_q + 64'd1 : 64'd1;
                res_next.evicted      = !hit_reg;
                res_next.evicted_address = hit_reg ? 32'd0 : key_q;
                if (slot_reg != head_reg)
                begin
                    next_we = 1'b1;
                    next_wa = prev_q;
                    next_wd = next_q;
                    if (slot_reg == tail_reg)
                    begin
                        tail_next = prev_q;
                    end
                    else
                    begin
                        prev_we = 1'b1;
                        prev_wa = next_q;
                        prev_wd = prev_q;
                    end
                end
                state_next = ST_MOV2;
            end
            ST_MOV2:
            begin
                // relink at the head and store the new count (and the key on a miss)
                cnt_we = 1'b1;
                cnt_wd = res_reg.packet_total;
                key_we = !hit_reg;
                if (slot_reg != head_reg)
                begin
                    next_we   = 1'b1;
                    prev_we   = 1'b1;
                    head_next = slot_reg;
                end
                state_next = ST_DONE;
            end
            ST_INS:
            begin
                key_we = 1'b1;
                cnt_we = 1'b1;
                if (used_reg != '0)
                begin
                    next_we = 1'b1;
                    prev_we = 1'b1;
                end
                else
                begin
                    tail_next = slot_reg;
                end
                head_next = slot_reg;
                used_next = used_reg + 1'b1;
                res_next.outcome      = OUTCOME_COUNTED;
                res_next.flow_address = addr_reg;
                res_next.packet_total = 64'd1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!ovalid_reg || out_ch.ready)
                begin
                    out_next    = res_reg;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            used_reg   <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        ridx_reg <= ridx_next;
        slot_reg <= slot_next;
        hit_reg  <= hit_next;
        addr_reg <= addr_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire
